FILE: sv/ldu_sparse_matvec_unit_assert.svh
// Assertion macros shared by the sparse mat-vec unit.
`ifndef LDU_SPARSE_MATVEC_UNIT_ASSERT_SVH
`define LDU_SPARSE_MATVEC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LDU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/ldu_pkg.sv
// Types, constants and helpers of the sparse mat-vec unit.
`default_nettype none

package ldu_pkg;

   localparam int NUM_CELLS = 1024;
   localparam int CELL_BITS = 10;
   localparam int ADDR_BITS = $clog2(NUM_CELLS);
   localparam int DATA_BITS = 32;
   localparam int YW_BITS   = DATA_BITS + 1;
   localparam int PROD_BITS = 2 * DATA_BITS;
   localparam int FRAC_BITS = 16;

   localparam logic [DATA_BITS-1:0] DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_FACE  = 2'd1,
      REQ_IFACE = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RND,
      ST_ACC1,
      ST_ACC2,
      ST_RSP
   } seq_state_type;

   typedef enum logic [1:0] {
      MUL_A_V,
      MUL_A_XL,
      MUL_B_XU
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_mode_type;

   typedef struct packed {
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         rnd_en;
      logic         acc_en;
      acc_mode_type acc_mode;
      logic         acc_fwd;
   } path_ctrl_type;

   typedef struct packed {
      logic                 x_rd_en;
      logic [ADDR_BITS-1:0] x_rd_addr_first;
      logic [ADDR_BITS-1:0] x_rd_addr_second;
      logic                 x_we;
      logic [ADDR_BITS-1:0] x_wr_addr;
      logic                 y_rd_en;
      logic [ADDR_BITS-1:0] y_rd_addr;
      logic                 y_we;
      logic [ADDR_BITS-1:0] y_wr_addr;
   } store_ctrl_type;

   function automatic logic cell_in_range(input logic [CELL_BITS-1:0] c);
      return 32'(c) < 32'(NUM_CELLS);
   endfunction

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [CELL_BITS-1:0] c);
      return ADDR_BITS'(c);
   endfunction

endpackage

`default_nettype wire

FILE: sv/ldu_req_if.sv
// Request channel of the sparse mat-vec unit.
`default_nettype none

interface ldu_req_if
   import ldu_pkg::*;
;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic [CELL_BITS-1:0]        first_cell;
   logic [CELL_BITS-1:0]        second_cell;
   logic signed [DATA_BITS-1:0] coeff_a;
   logic signed [DATA_BITS-1:0] coeff_b;
   logic signed [DATA_BITS-1:0] vector_value;

   modport source (
      output valid, req_type, first_cell, second_cell, coeff_a, coeff_b, vector_value,
      input  ready
   );

   modport sink (
      input  valid, req_type, first_cell, second_cell, coeff_a, coeff_b, vector_value,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/ldu_rsp_if.sv
// Response channel of the sparse mat-vec unit.
`default_nettype none

interface ldu_rsp_if
   import ldu_pkg::*;
;
   logic                        valid;
   logic                        ready;
   logic [CELL_BITS-1:0]        cell_out;
   logic signed [DATA_BITS-1:0] product_value;
   logic signed [DATA_BITS-1:0] source_value;
   logic                        saturated;

   modport source (
      output valid, cell_out, product_value, source_value, saturated,
      input  ready
   );

   modport sink (
      input  valid, cell_out, product_value, source_value, saturated,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/ldu_cell_store.sv
// Per-cell x and y memories, registered read data.
`default_nettype none

module ldu_cell_store
   import ldu_pkg::*;
(
   input  wire logic                 clock,
   input  wire store_ctrl_type       store_ctrl,
   input  wire logic [DATA_BITS-1:0] x_wr_data,
   input  wire logic [YW_BITS-1:0]   y_wr_data,
   output logic [DATA_BITS-1:0]      x_first_rd,
   output logic [DATA_BITS-1:0]      x_second_rd,
   output logic [YW_BITS-1:0]        y_rd
);

   // y word carries the saturation mark in its top bit
   logic [DATA_BITS-1:0] x_mem [NUM_CELLS];
   logic [YW_BITS-1:0]   y_mem [NUM_CELLS];

   logic [DATA_BITS-1:0] x_first_rd_ff;
   logic [DATA_BITS-1:0] x_second_rd_ff;
   logic [YW_BITS-1:0]   y_rd_ff;

   always_ff @(posedge clock) begin
      if (store_ctrl.x_we) begin
         x_mem[store_ctrl.x_wr_addr] <= x_wr_data;
      end
      if (store_ctrl.x_rd_en) begin
         x_first_rd_ff  <= x_mem[store_ctrl.x_rd_addr_first];
         x_second_rd_ff <= x_mem[store_ctrl.x_rd_addr_second];
      end
   end

   always_ff @(posedge clock) begin
      if (store_ctrl.y_we) begin
         y_mem[store_ctrl.y_wr_addr] <= y_wr_data;
      end
      if (store_ctrl.y_rd_en) begin
         y_rd_ff <= y_mem[store_ctrl.y_rd_addr];
      end
   end

   assign x_first_rd  = x_first_rd_ff;
   assign x_second_rd = x_second_rd_ff;
   assign y_rd        = y_rd_ff;

endmodule

`default_nettype wire

FILE: sv/ldu_mac_path.sv
// Shared multiplier, rounder and saturating accumulator.
`default_nettype none

module ldu_mac_path
   import ldu_pkg::*;
(
   input  wire logic                        clock,
   input  wire path_ctrl_type               path_ctrl,
   input  wire logic signed [DATA_BITS-1:0] coeff_a,
   input  wire logic signed [DATA_BITS-1:0] coeff_b,
   input  wire logic signed [DATA_BITS-1:0] vector_value,
   input  wire logic [DATA_BITS-1:0]        x_first,
   input  wire logic [DATA_BITS-1:0]        x_second,
   input  wire logic [YW_BITS-1:0]          y_rd,
   output logic [YW_BITS-1:0]               y_wr_data
);

   localparam logic signed [PROD_BITS-1:0] RND_ADD =
      (FRAC_BITS > 0) ? (PROD_BITS'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0))
                      : PROD_BITS'(0);

   logic signed [DATA_BITS-1:0] op_a;
   logic signed [DATA_BITS-1:0] op_b;
   logic signed [PROD_BITS-1:0] product;
   logic signed [PROD_BITS-1:0] rsum;
   logic signed [PROD_BITS-1:0] shifted;
   logic                        rnd_fits;
   logic [DATA_BITS-1:0]        q_in;
   logic                        q_sat_in;

   logic signed [PROD_BITS-1:0] prod_ff;
   logic [DATA_BITS-1:0]        q_ff;
   logic                        q_sat_ff;
   logic [YW_BITS-1:0]          last_wr_ff;

   logic [YW_BITS-1:0]          base;
   logic [DATA_BITS:0]          sum;
   logic                        add_sat;
   logic [DATA_BITS-1:0]        sum_clamped;

   // multiplier operands
   always_comb begin
      op_a = (path_ctrl.mul_sel == MUL_B_XU) ? coeff_b : coeff_a;
      unique case (path_ctrl.mul_sel)
         MUL_A_V:  op_b = vector_value;
         MUL_A_XL: op_b = x_first;
         MUL_B_XU: op_b = x_second;
         default:  op_b = vector_value;
      endcase
      product = PROD_BITS'(op_a) * PROD_BITS'(op_b);
   end

   // round half up, floor shift, clamp to 32 bits
   always_comb begin
      rsum     = prod_ff + RND_ADD;
      shifted  = rsum >>> FRAC_BITS;
      rnd_fits = (&shifted[PROD_BITS-1:DATA_BITS-1]) | ~(|shifted[PROD_BITS-1:DATA_BITS-1]);
      q_sat_in = ~rnd_fits;
      if (rnd_fits) begin
         q_in = shifted[DATA_BITS-1:0];
      end else begin
         q_in = shifted[PROD_BITS-1] ? DATA_MIN : DATA_MAX;
      end
   end

   // accumulate into y; a face on one cell reuses the value just written
   always_comb begin
      base = path_ctrl.acc_fwd ? last_wr_ff : y_rd;
      if (path_ctrl.acc_mode == ACC_SUB) begin
         sum = {base[DATA_BITS-1], base[DATA_BITS-1:0]} - {q_ff[DATA_BITS-1], q_ff};
      end else begin
         sum = {base[DATA_BITS-1], base[DATA_BITS-1:0]} + {q_ff[DATA_BITS-1], q_ff};
      end
      add_sat = sum[DATA_BITS] ^ sum[DATA_BITS-1];
      if (add_sat) begin
         sum_clamped = sum[DATA_BITS] ? DATA_MIN : DATA_MAX;
      end else begin
         sum_clamped = sum[DATA_BITS-1:0];
      end
      if (path_ctrl.acc_mode == ACC_LOAD) begin
         y_wr_data = {q_sat_ff, q_ff};
      end else begin
         y_wr_data = {base[DATA_BITS] | q_sat_ff | add_sat, sum_clamped};
      end
   end

   always_ff @(posedge clock) begin
      if (path_ctrl.mul_en) begin
         prod_ff <= product;
      end
      if (path_ctrl.rnd_en) begin
         q_ff     <= q_in;
         q_sat_ff <= q_sat_in;
      end
      if (path_ctrl.acc_en) begin
         last_wr_ff <= y_wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ldu_sparse_matvec_unit.sv
// Top level of the LDU sparse matrix-vector unit: sequencer, response register, datapath.
// One transaction at a time. Load and interface items pass the multiply, round and accumulate
// states; face items add a second accumulate state (two read-modify-writes on the y memory
// through one multiplier); read items wait in the response state while the response stalls.
// Synchronous active-high reset clears the sequencer and response valid; memories are not cleared.
`default_nettype none

`include "ldu_sparse_matvec_unit_assert.svh"

module ldu_sparse_matvec_unit
   import ldu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ldu_req_if.sink    req_if,
   ldu_rsp_if.source  rsp_if
);

   seq_state_type               state_ff, state_in;
   req_kind_type                kind_ff;
   logic [CELL_BITS-1:0]        c1_ff;
   logic [CELL_BITS-1:0]        c2_ff;
   logic signed [DATA_BITS-1:0] a_ff;
   logic signed [DATA_BITS-1:0] b_ff;
   logic signed [DATA_BITS-1:0] v_ff;
   logic                        ok_ff;
   logic                        same_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CELL_BITS-1:0]        rsp_cell_ff;
   logic [DATA_BITS-1:0]        rsp_prod_ff;
   logic [DATA_BITS-1:0]        rsp_src_ff;
   logic                        rsp_sat_ff;

   logic                        accept;
   logic                        rsp_load;
   req_kind_type                in_kind;
   logic                        in_ok;
   store_ctrl_type              store_ctrl;
   path_ctrl_type               path_ctrl;

   logic [DATA_BITS-1:0]        x_first_rd;
   logic [DATA_BITS-1:0]        x_second_rd;
   logic [YW_BITS-1:0]          y_rd;
   logic [YW_BITS-1:0]          y_wr_data;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign in_kind      = req_kind_type'(req_if.req_type);
   assign in_ok        = cell_in_range(req_if.first_cell) &&
                         ((in_kind != REQ_FACE) || cell_in_range(req_if.second_cell));

   always_comb begin
      state_in   = state_ff;
      rsp_load   = 1'b0;
      store_ctrl = '0;
      path_ctrl  = '{mul_en: 1'b0, mul_sel: MUL_A_V, rnd_en: 1'b0, acc_en: 1'b0,
                     acc_mode: ACC_ADD, acc_fwd: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            // operands are fetched on the accepting edge
            store_ctrl.x_rd_en          = accept;
            store_ctrl.x_rd_addr_first  = cell_addr(req_if.first_cell);
            store_ctrl.x_rd_addr_second = cell_addr(req_if.second_cell);
            store_ctrl.y_rd_en          = accept;
            store_ctrl.y_rd_addr        = (in_kind == REQ_FACE) ?
                                          cell_addr(req_if.second_cell) :
                                          cell_addr(req_if.first_cell);
            if (accept) begin
               state_in = (in_kind == REQ_READ) ? ST_RSP : ST_MUL;
            end
         end
         ST_MUL: begin
            path_ctrl.mul_en  = 1'b1;
            path_ctrl.mul_sel = (kind_ff == REQ_FACE) ? MUL_A_XL : MUL_A_V;
            state_in          = ST_RND;
         end
         ST_RND: begin
            path_ctrl.rnd_en  = 1'b1;
            // upper term product overlaps rounding of the lower term
            path_ctrl.mul_en  = (kind_ff == REQ_FACE);
            path_ctrl.mul_sel = MUL_B_XU;
            state_in          = ST_ACC1;
         end
         ST_ACC1: begin
            path_ctrl.acc_en   = 1'b1;
            path_ctrl.acc_mode = (kind_ff == REQ_LOAD)  ? ACC_LOAD :
                                 (kind_ff == REQ_IFACE) ? ACC_SUB : ACC_ADD;
            store_ctrl.y_we      = ok_ff;
            store_ctrl.y_wr_addr = (kind_ff == REQ_FACE) ? cell_addr(c2_ff) : cell_addr(c1_ff);
            store_ctrl.x_we      = ok_ff && (kind_ff == REQ_LOAD);
            store_ctrl.x_wr_addr = cell_addr(c1_ff);
            if (kind_ff == REQ_FACE) begin
               path_ctrl.rnd_en     = 1'b1;
               store_ctrl.y_rd_en   = 1'b1;
               store_ctrl.y_rd_addr = cell_addr(c1_ff);
               state_in             = ST_ACC2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACC2: begin
            path_ctrl.acc_en     = 1'b1;
            path_ctrl.acc_mode   = ACC_ADD;
            path_ctrl.acc_fwd    = same_ff;
            store_ctrl.y_we      = ok_ff;
            store_ctrl.y_wr_addr = cell_addr(c1_ff);
            state_in             = ST_IDLE;
         end
         ST_RSP: begin
            rsp_load = !rsp_valid_ff || rsp_if.ready;
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= in_kind;
         c1_ff   <= req_if.first_cell;
         c2_ff   <= req_if.second_cell;
         a_ff    <= req_if.coeff_a;
         b_ff    <= req_if.coeff_b;
         v_ff    <= req_if.vector_value;
         ok_ff   <= in_ok;
         same_ff <= (req_if.first_cell == req_if.second_cell);
      end
      if (rsp_load) begin
         rsp_cell_ff <= c1_ff;
         rsp_prod_ff <= ok_ff ? y_rd[DATA_BITS-1:0] : '0;
         rsp_src_ff  <= ok_ff ? x_first_rd : '0;
         rsp_sat_ff  <= ok_ff && y_rd[DATA_BITS];
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cell_out      = rsp_cell_ff;
   assign rsp_if.product_value = rsp_prod_ff;
   assign rsp_if.source_value  = rsp_src_ff;
   assign rsp_if.saturated     = rsp_sat_ff;

   ldu_cell_store u_store (
      .clock       (clock),
      .store_ctrl  (store_ctrl),
      .x_wr_data   (v_ff),
      .y_wr_data   (y_wr_data),
      .x_first_rd  (x_first_rd),
      .x_second_rd (x_second_rd),
      .y_rd        (y_rd)
   );

   ldu_mac_path u_mac (
      .clock        (clock),
      .path_ctrl    (path_ctrl),
      .coeff_a      (a_ff),
      .coeff_b      (b_ff),
      .vector_value (v_ff),
      .x_first      (x_first_rd),
      .x_second     (x_second_rd),
      .y_rd         (y_rd),
      .y_wr_data    (y_wr_data)
   );

   `LDU_ASSERT_IMP(a_y_write_phase, clock, reset, store_ctrl.y_we,
      (state_ff == ST_ACC1) || (state_ff == ST_ACC2), "y write outside accumulate phase")
   `LDU_ASSERT_IMP(a_x_write_load, clock, reset, store_ctrl.x_we,
      (kind_ff == REQ_LOAD) && (state_ff == ST_ACC1), "x write not from a load")
   `LDU_ASSERT_NEXT(a_read_to_rsp, clock, reset, accept && (in_kind == REQ_READ),
      state_ff == ST_RSP, "read transaction did not reach response state")
   `LDU_ASSERT_NEXT(a_face_second_term, clock, reset,
      (state_ff == ST_ACC1) && (kind_ff == REQ_FACE), state_ff == ST_ACC2,
      "face lost its upper term")
   `LDU_ASSERT_IMP(a_fwd_same_cell, clock, reset, path_ctrl.acc_fwd,
      (c1_ff == c2_ff) && (state_ff == ST_ACC2), "forwarding without a shared cell")

endmodule

`default_nettype wire

FILE: verif/ldu_sparse_matvec_unit_test.sv
// Self-checking testbench for the LDU sparse matrix-vector unit.
module ldu_sparse_matvec_unit_test
   import ldu_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     STALL_LIMIT  = 1000;
   localparam int     POOL_SIZE    = 20;
   localparam int     RANDOM_ITEMS = 480;
   localparam int     CALM_ITEMS   = 60;
   localparam longint Q_HI         = 64'sd2147483647;
   localparam longint Q_LO         = -64'sd2147483648;

   localparam logic signed [DATA_BITS-1:0] Q_ONE      = 32'sh0001_0000;
   localparam logic signed [DATA_BITS-1:0] Q_MINUS1   = 32'shFFFF_0000;
   localparam logic signed [DATA_BITS-1:0] Q_HALF_ULP = 32'sh0000_8000;

   typedef struct {
      req_kind_type                kind;
      logic [CELL_BITS-1:0]        first_cell;
      logic [CELL_BITS-1:0]        second_cell;
      logic signed [DATA_BITS-1:0] coeff_a;
      logic signed [DATA_BITS-1:0] coeff_b;
      logic signed [DATA_BITS-1:0] vector_value;
   } matvec_request_type;

   typedef struct {
      logic [CELL_BITS-1:0]        cell_num;
      logic signed [DATA_BITS-1:0] product;
      logic signed [DATA_BITS-1:0] source;
      logic                        saturated;
   } matvec_result_type;

   // Keeps its own copy of x, y and the saturation marks and queues the
   // expected answer of every accepted read.
   class ldu_product_tracker;
      bit signed [DATA_BITS-1:0] source_values[NUM_CELLS];
      bit signed [DATA_BITS-1:0] product_values[NUM_CELLS];
      bit                        sat_marks[NUM_CELLS];
      matvec_result_type         pending_reads[$];
      int                        mismatch_count;

      function bit signed [DATA_BITS-1:0] saturate(longint v, inout bit hit);
         if (v > Q_HI) begin
            hit = 1'b1;
            return DATA_MAX;
         end
         if (v < Q_LO) begin
            hit = 1'b1;
            return DATA_MIN;
         end
         return v[DATA_BITS-1:0];
      endfunction

      // Q-format product, rounded half up, then clamped.
      function bit signed [DATA_BITS-1:0] fixed_mul(bit signed [DATA_BITS-1:0] a,
                                                    bit signed [DATA_BITS-1:0] b,
                                                    inout bit hit);
         longint p;
         p = longint'(a) * longint'(b);
         if (FRAC_BITS > 0)
            p = p + (longint'(1) << (FRAC_BITS - 1));
         p = p >>> FRAC_BITS;
         return saturate(p, hit);
      endfunction

      function void accumulate(int c, bit signed [DATA_BITS-1:0] term, inout bit hit);
         product_values[c] = saturate(longint'(product_values[c]) + longint'(term), hit);
         if (hit)
            sat_marks[c] = 1'b1;
      endfunction

      function void apply_request(matvec_request_type r);
         bit                        hit;
         int                        l;
         int                        u;
         bit signed [DATA_BITS-1:0] term;
         matvec_result_type         due;
         hit = 1'b0;
         l   = int'(r.first_cell);
         u   = int'(r.second_cell);
         case (r.kind)
            REQ_LOAD: begin
               if (l < NUM_CELLS) begin
                  source_values[l]  = r.vector_value;
                  product_values[l] = fixed_mul(r.coeff_a, r.vector_value, hit);
                  sat_marks[l]      = hit;
               end
            end
            REQ_FACE: begin
               // lower term into the neighbour first, then upper term into the owner
               if (l < NUM_CELLS && u < NUM_CELLS) begin
                  term = fixed_mul(r.coeff_a, source_values[l], hit);
                  accumulate(u, term, hit);
                  hit  = 1'b0;
                  term = fixed_mul(r.coeff_b, source_values[u], hit);
                  accumulate(l, term, hit);
               end
            end
            REQ_IFACE: begin
               if (l < NUM_CELLS) begin
                  term = fixed_mul(r.coeff_a, r.vector_value, hit);
                  product_values[l] = saturate(longint'(product_values[l]) - longint'(term),
                                               hit);
                  if (hit)
                     sat_marks[l] = 1'b1;
               end
            end
            default: begin
               due.cell_num = r.first_cell;
               if (l < NUM_CELLS) begin
                  due.product   = product_values[l];
                  due.source    = source_values[l];
                  due.saturated = sat_marks[l];
               end else begin
                  due.product   = '0;
                  due.source    = '0;
                  due.saturated = 1'b0;
               end
               pending_reads = {pending_reads, due};
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_read(matvec_result_type got);
         matvec_result_type due;
         if (pending_reads.size() == 0) begin
            report_mismatch($sformatf("unexpected response for cell %0d", got.cell_num));
            return;
         end
         due = pending_reads.pop_front();
         if (got.cell_num !== due.cell_num)
            report_mismatch($sformatf("cell_out %0d, want %0d", got.cell_num, due.cell_num));
         if (got.product !== due.product)
            report_mismatch($sformatf("cell %0d product_value %h, want %h",
                                      due.cell_num, got.product, due.product));
         if (got.source !== due.source)
            report_mismatch($sformatf("cell %0d source_value %h, want %h",
                                      due.cell_num, got.source, due.source));
         if (got.saturated !== due.saturated)
            report_mismatch($sformatf("cell %0d saturated %b, want %b",
                                      due.cell_num, got.saturated, due.saturated));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ldu_req_if req_ch ();
   ldu_rsp_if rsp_ch ();

   ldu_sparse_matvec_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   ldu_product_tracker   tracker = new();
   bit                   cell_loaded[NUM_CELLS];
   logic [CELL_BITS-1:0] loaded_cells[$];
   logic [CELL_BITS-1:0] cell_pool[$];
   bit                   calm_tail;
   int                   stall_left;
   int                   quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: random back-pressure bursts; none start in the calm tail.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 16);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      matvec_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.cell_num  = rsp_ch.cell_out;
         got.product   = rsp_ch.product_value;
         got.source    = rsp_ch.source_value;
         got.saturated = rsp_ch.saturated;
         tracker.check_read(got);
      end
   end

   // Watchdog on cycles in which no transaction completes on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic matvec_request_type make_request(req_kind_type k, int c1, int c2,
                                                       logic signed [DATA_BITS-1:0] a,
                                                       logic signed [DATA_BITS-1:0] b,
                                                       logic signed [DATA_BITS-1:0] v);
      matvec_request_type r;
      r.kind         = k;
      r.first_cell   = CELL_BITS'(c1);
      r.second_cell  = CELL_BITS'(c2);
      r.coeff_a      = a;
      r.coeff_b      = b;
      r.vector_value = v;
      return r;
   endfunction

   // Mostly modest magnitudes so sums do not pin at the rails straight away.
   function automatic logic signed [DATA_BITS-1:0] random_q();
      case ($urandom_range(0, 19))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return '0;
         3:       return 32'sd1;
         4:       return -32'sd1;
         5:       return Q_HALF_ULP;
         6, 7, 8: return $urandom;
         default: return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
      endcase
   endfunction

   function automatic logic [CELL_BITS-1:0] pick_loaded();
      if ($urandom_range(0, 3) != 0)
         return cell_pool[$urandom_range(0, cell_pool.size() - 1)];
      return loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
   endfunction

   // Only loaded cells are ever read, directly or through a face or interface.
   function automatic matvec_request_type random_request();
      matvec_request_type r;
      int                 pick;
      r = make_request(REQ_READ, 0, $urandom_range(0, NUM_CELLS - 1),
                       random_q(), random_q(), random_q());
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.kind = REQ_LOAD;
         if ($urandom_range(0, 4) == 0)
            r.first_cell = CELL_BITS'($urandom_range(0, NUM_CELLS - 1));
         else
            r.first_cell = cell_pool[$urandom_range(0, cell_pool.size() - 1)];
      end else if (pick < 55) begin
         r.kind        = REQ_FACE;
         r.first_cell  = pick_loaded();
         r.second_cell = ($urandom_range(0, 15) == 0) ? r.first_cell : pick_loaded();
      end else if (pick < 75) begin
         r.kind       = REQ_IFACE;
         r.first_cell = pick_loaded();
      end else begin
         r.first_cell = pick_loaded();
      end
      return r;
   endfunction

   task automatic send_item(input matvec_request_type r);
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= r.kind;
      req_ch.first_cell   <= r.first_cell;
      req_ch.second_cell  <= r.second_cell;
      req_ch.coeff_a      <= r.coeff_a;
      req_ch.coeff_b      <= r.coeff_b;
      req_ch.vector_value <= r.vector_value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.apply_request(r);
      if (r.kind == REQ_LOAD && !cell_loaded[r.first_cell]) begin
         cell_loaded[r.first_cell] = 1'b1;
         loaded_cells = {loaded_cells, r.first_cell};
      end
   endtask

   // Random gap on the request side before the transaction, except in the calm tail.
   task automatic issue_request(input matvec_request_type r);
      int gap;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      send_item(r);
   endtask

   initial begin
      reset               = 1'b1;
      rsp_ch.ready        = 1'b0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_LOAD;
      req_ch.first_cell   = '0;
      req_ch.second_cell  = '0;
      req_ch.coeff_a      = '0;
      req_ch.coeff_b      = '0;
      req_ch.vector_value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: rails, rounding ties, equal-cell face, saturation and its clearing
      issue_request(make_request(REQ_LOAD, 0, 0, Q_ONE, 0, 32'sh0002_0000));
      issue_request(make_request(REQ_LOAD, 1023, 0, DATA_MAX, 0, DATA_MAX));
      issue_request(make_request(REQ_LOAD, 341, 0, DATA_MIN, 0, DATA_MIN));
      issue_request(make_request(REQ_LOAD, 682, 0, -32'sd1, 0, Q_HALF_ULP));
      issue_request(make_request(REQ_LOAD, 1, 0, DATA_MIN, 0, Q_ONE));
      issue_request(make_request(REQ_LOAD, 2, 0, 32'sd1, 0, Q_HALF_ULP));
      foreach (loaded_cells[i])
         issue_request(make_request(REQ_READ, loaded_cells[i], 0, 0, 0, 0));
      issue_request(make_request(REQ_FACE, 0, 1, Q_ONE, Q_MINUS1, 0));
      issue_request(make_request(REQ_FACE, 341, 341, 32'sh0001_8000, 32'shFFFF_8000, 0));
      issue_request(make_request(REQ_FACE, 1023, 0, Q_ONE, 0, 0));
      issue_request(make_request(REQ_IFACE, 0, 0, DATA_MAX, 0, DATA_MIN));
      issue_request(make_request(REQ_IFACE, 682, 0, 32'sh0002_0000, 0, Q_MINUS1));
      issue_request(make_request(REQ_LOAD, 1023, 0, Q_ONE, 0, 32'shFFFD_0000));
      issue_request(make_request(REQ_READ, 0, 0, 0, 0, 0));
      issue_request(make_request(REQ_READ, 1, 0, 0, 0, 0));
      issue_request(make_request(REQ_READ, 1023, 0, 0, 0, 0));
      issue_request(make_request(REQ_READ, 341, 0, 0, 0, 0));
      issue_request(make_request(REQ_READ, 682, 0, 0, 0, 0));

      // random: load a small working set, then mixed traffic over it
      repeat (POOL_SIZE)
         cell_pool = {cell_pool, CELL_BITS'($urandom_range(0, NUM_CELLS - 1))};
      foreach (cell_pool[i])
         issue_request(make_request(REQ_LOAD, cell_pool[i], $urandom_range(0, NUM_CELLS - 1),
                                    random_q(), random_q(), random_q()));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            calm_tail = 1'b1;
         issue_request(random_request());
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (tracker.pending_reads.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
